[hdl/polynomial_horner_evaluator_assert.svh]
// Assertion macros for the checker file of the Horner evaluator.
// Expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef POLYNOMIAL_HORNER_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_HORNER_EVALUATOR_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define PHE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define PHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also checks during reset.
`define PHE_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/phe_pkg.sv]
// Package of the Horner polynomial evaluator: payload structs, action codes,
// fixed widths and the integral reciprocal table. Depends on nothing.
`default_nettype none

package phe_pkg;

  localparam int unsigned DATA_W    = 32;  // Q16.16 ports and registers
  localparam int unsigned ACC_W     = 48;  // Q32.16 accumulator
  localparam int unsigned TERM_W    = 36;  // widest Horner term (7 * coef)
  localparam int unsigned NUM_REGS  = 8;   // coef_0 .. coef_7
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACTION_W  = 2;

  localparam logic [ACTION_W-1:0] ACT_VALUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DERIV = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INTEG = 2'd2;

  // round(2^32 / (i+1)), unsigned Q1.32
  localparam logic [32:0] RECIP_Q32 [NUM_REGS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827883,  33'd613566757,  33'd536870912
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] point_x;
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] intercept;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] poly_result;
    logic                     overflow;
  } out_t;

endpackage

`default_nettype wire

[hdl/polynomial_horner_evaluator.sv]
// Top level of the Horner polynomial evaluator: coefficient registers,
// derived term tables and the pipelined Horner chain. Depends on phe_pkg.
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+----------------------------
// in       | input     | in_valid_i / in_ready_o   | in_data_i  (phe_pkg::in_t)
// out      | output    | out_valid_o / out_ready_i | out_data_o (phe_pkg::out_t)
// cfg      | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// The chain is DEGREE+2 Horner steps of two stages each (partial products, then
// round/add/saturate), followed by the output saturation register. One transfer
// is taken every cycle while the output side takes results; the 32x32 partial
// product of each step sets the stage depth. Reset clears the valid bits and
// the coefficients to 0. A stall on the output freezes the whole chain, so
// nothing is lost or repeated.

module polynomial_horner_evaluator #(
  parameter int unsigned DEGREE = 7
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  phe_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output phe_pkg::out_t                       out_data_o,
  input  wire                                 cfg_we_i,
  input  wire  [phe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [phe_pkg::DATA_W-1:0]          cfg_data_i
);

  // Horner steps: the integral has DEGREE+2 terms; shorter term lists are
  // padded with leading zeros, which leave the accumulator at zero.
  localparam int unsigned NSTEP  = DEGREE + 2;
  localparam int unsigned DW     = phe_pkg::DATA_W;
  localparam int unsigned AW     = phe_pkg::ACC_W;
  localparam int unsigned TW     = phe_pkg::TERM_W;
  localparam int unsigned NREG   = phe_pkg::NUM_REGS;
  localparam int unsigned HIX_W  = 2 * DW;          // hi(acc) * x
  localparam int unsigned LOX_W  = 17 + DW;         // lo(acc) * x
  localparam int unsigned RND_W  = LOX_W + 1;
  localparam int unsigned SUM_W  = HIX_W + 2;
  localparam int unsigned IP_W   = 2 * DW + 2;

  localparam logic signed [SUM_W-1:0] ACC_HI = {{(SUM_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [AW-1:0]    RES_HI = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0]    RES_LO = ~RES_HI;
  localparam logic signed [IP_W-1:0]  IP_HALF = IP_W'(64'sd2147483648);

  typedef struct packed {
    logic signed [AW-1:0]              acc;
    logic signed [DW-1:0]              x;
    logic [phe_pkg::ACTION_W-1:0]      action;
    logic signed [DW-1:0]              icpt;
    logic                              ovf;
  } acc_t;

  typedef struct packed {
    logic signed [HIX_W-1:0]           hi_x;
    logic signed [LOX_W-1:0]           lo_x;
    logic signed [DW-1:0]              x;
    logic [phe_pkg::ACTION_W-1:0]      action;
    logic signed [DW-1:0]              icpt;
    logic                              ovf;
  } prod_t;

  // ---------------------------------------------------------------------------
  // Coefficients and derived term tables. The tables are registered and follow
  // a coefficient write in the next cycle; a term is first read once the item sits in step 0's product register.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] coef_q  [NREG];
  logic signed [TW-1:0] deriv_q [NREG-1];
  logic signed [TW-1:0] deriv_d [NREG-1];
  logic signed [DW-1:0] integ_q [NREG];
  logic signed [DW-1:0] integ_d [NREG];
  logic signed [IP_W-1:0] integ_prod [NREG];

  always_comb begin
    for (int i = 0; i < int'(NREG) - 1; i++) begin
      // d_i = (i+1) * coef_(i+1), exact
      deriv_d[i] = TW'(coef_q[i+1]) * $signed(TW'(i + 1));
    end
    for (int i = 0; i < int'(NREG); i++) begin
      // e_(i+1) = floor((coef_i * r_i + 2^31) / 2^32)
      integ_prod[i] = IP_W'(coef_q[i]) * $signed({1'b0, phe_pkg::RECIP_Q32[i]})
                      + IP_HALF;
      integ_d[i]    = integ_prod[i][2*DW-1:DW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NREG); i++) begin
        coef_q[i]  <= '0;
        integ_q[i] <= '0;
      end
      for (int i = 0; i < int'(NREG) - 1; i++) begin
        deriv_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        coef_q[cfg_index_i] <= $signed(cfg_data_i);
      end
      for (int i = 0; i < int'(NREG); i++) begin
        integ_q[i] <= integ_d[i];
      end
      for (int i = 0; i < int'(NREG) - 1; i++) begin
        deriv_q[i] <= deriv_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers. Step k consumes term index NSTEP-1-k.
  // ---------------------------------------------------------------------------
  logic [NSTEP-1:0] va_q, vb_q;
  prod_t            pa_q [NSTEP];
  prod_t            pa_d [NSTEP];
  acc_t             ab_q [NSTEP];
  acc_t             ab_d [NSTEP];
  acc_t             src  [NSTEP];
  logic [NSTEP-1:0] src_v;
  logic             out_v_q;
  phe_pkg::out_t    out_q, out_d;
  logic             adv;

  // Term candidates per step, fixed at elaboration by the step's index.
  wire signed [TW-1:0] t_val_w [NSTEP];
  wire signed [TW-1:0] t_der_w [NSTEP];
  wire signed [TW-1:0] t_int_w [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_term
    localparam int unsigned J = NSTEP - 1 - k;
    if (J <= DEGREE) begin : g_val
      assign t_val_w[k] = TW'(coef_q[J]);
    end else begin : g_val_pad
      assign t_val_w[k] = '0;
    end
    if (J + 1 <= DEGREE) begin : g_der
      assign t_der_w[k] = deriv_q[J];
    end else begin : g_der_pad
      assign t_der_w[k] = '0;
    end
    if (J == 0) begin : g_icpt
      assign t_int_w[k] = TW'(pa_q[k].icpt);
    end else begin : g_int
      assign t_int_w[k] = TW'(integ_q[J-1]);
    end
  end

  // Advance the whole chain whenever the output register can take a result.
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    logic signed [TW-1:0]    term;
    logic signed [RND_W-1:0] rnd_sum;
    logic signed [SUM_W-1:0] sum;
    logic signed [AW-1:0]    fin;

    // Step 0 starts from a zero accumulator.
    src[0].acc    = '0;
    src[0].x      = in_data_i.point_x;
    src[0].action = in_data_i.action;
    src[0].icpt   = in_data_i.intercept;
    src[0].ovf    = 1'b0;
    src_v[0]      = in_valid_i;
    for (int k = 1; k < int'(NSTEP); k++) begin
      src[k]   = ab_q[k-1];
      src_v[k] = vb_q[k-1];
    end

    for (int k = 0; k < int'(NSTEP); k++) begin
      // Partial products: acc = hi * 2^16 + lo
      pa_d[k].hi_x   = $signed(src[k].acc[AW-1:16]) * src[k].x;
      pa_d[k].lo_x   = $signed({1'b0, src[k].acc[15:0]}) * src[k].x;
      pa_d[k].x      = src[k].x;
      pa_d[k].action = src[k].action;
      pa_d[k].icpt   = src[k].icpt;
      pa_d[k].ovf    = src[k].ovf;

      case (pa_q[k].action)
        phe_pkg::ACT_VALUE: term = t_val_w[k];
        phe_pkg::ACT_DERIV: term = t_der_w[k];
        phe_pkg::ACT_INTEG: term = t_int_w[k];
        default:            term = '0;
      endcase

      // Round to nearest, add the term, saturate to 48 bits.
      rnd_sum = RND_W'(pa_q[k].lo_x) + RND_W'(32'sd32768);
      sum     = SUM_W'(pa_q[k].hi_x) + SUM_W'($signed(rnd_sum[RND_W-1:16]))
                + SUM_W'(term);
      ab_d[k].x      = pa_q[k].x;
      ab_d[k].action = pa_q[k].action;
      ab_d[k].icpt   = pa_q[k].icpt;
      if (sum > ACC_HI) begin
        ab_d[k].acc = ACC_HI[AW-1:0];
        ab_d[k].ovf = 1'b1;
      end else if (sum < ACC_LO) begin
        ab_d[k].acc = ACC_LO[AW-1:0];
        ab_d[k].ovf = 1'b1;
      end else begin
        ab_d[k].acc = sum[AW-1:0];
        ab_d[k].ovf = pa_q[k].ovf;
      end
    end

    // Final saturation to the 32-bit result.
    fin = ab_q[NSTEP-1].acc;
    if (fin > RES_HI) begin
      out_d.poly_result = RES_HI[DW-1:0];
      out_d.overflow    = 1'b1;
    end else if (fin < RES_LO) begin
      out_d.poly_result = RES_LO[DW-1:0];
      out_d.overflow    = 1'b1;
    end else begin
      out_d.poly_result = fin[DW-1:0];
      out_d.overflow    = ab_q[NSTEP-1].ovf;
    end
  end

  // Valid bits: reset to empty, advance together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= '0;
      vb_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      va_q    <= src_v;
      vb_q    <= va_q;
      out_v_q <= vb_q[NSTEP-1];
    end
  end

  // Payload: load only where a valid item moves in; hold on a stall.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < int'(NSTEP); k++) begin
        if (src_v[k]) begin
          pa_q[k] <= pa_d[k];
        end
        if (va_q[k]) begin
          ab_q[k] <= ab_d[k];
        end
      end
      if (vb_q[NSTEP-1]) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hdl/phe_checker.sv]
// Port-level checker for the Horner evaluator, bound to the top level.
// Depends on phe_pkg and polynomial_horner_evaluator_assert.svh.
`default_nettype none
`include "polynomial_horner_evaluator_assert.svh"

module phe_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_i,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input wire phe_pkg::out_t out_data_i
);

  // Hold a stalled result.
  `PHE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

  // Refuse input only when a result waits on a stalled output.
  `PHE_ASSERT_IMPL(a_stall_src, !in_ready_i, out_valid_i && !out_ready_i, "input refused without output stall")

  // Drop all results while reset is held.
  `PHE_ASSERT_ALWAYS(a_reset_empty, !rst_ni, !out_valid_i, "result valid during reset")

endmodule

bind polynomial_horner_evaluator phe_checker u_phe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
